### rtl/ssnf_pkg.sv
`timescale 1ns / 1ps
package ssnf_pkg;

   // payload of one beat on the request channel
   typedef struct packed {
      logic signed [31:0] value;
      logic               alert_bit;
      logic               fpm_bit;
      logic               ft_bit;
   } req_type;

   typedef struct packed {
      logic [7:0] seg_byte0;
      logic [7:0] seg_byte1;
      logic [7:0] seg_byte2;
      logic [7:0] seg_byte3;
      logic [7:0] seg_byte4;
   } rsp_type;

   // classified item as held in the queue
   typedef struct packed {
      logic [31:0] mag;
      logic        neg;
      logic        pos;
      logic        mark;
      logic        alert;
      logic        fpm;
      logic        ft;
   } cls_type;

   typedef struct packed {
      logic    valid;
      cls_type cls;
   } push_type;

   // reduction moduli and their truncated reciprocals, scaled by 2^32
   localparam logic [16:0] MOD_BIG     = 17'd100000;
   localparam logic [16:0] MOD_SMALL   = 17'd10000;
   localparam logic [18:0] RECIP_BIG   = 19'd42949;
   localparam logic [18:0] RECIP_SMALL = 19'd429496;

   // divide by ten: (x * DIV10_MUL) >> DIV10_SHIFT, exact below 2^22
   localparam logic [19:0] DIV10_MUL   = 20'd838861;
   localparam int          DIV10_SHIFT = 23;

   localparam logic [9:0]  MAG_MARK_MIN = 10'd1000;

   localparam logic [3:0] CODE_BLANK = 4'd10;
   localparam logic [3:0] CODE_MINUS = 4'd11;
   localparam logic [7:0] MARK_BIT   = 8'h10;

   function automatic logic [7:0] seg_pattern(input logic [3:0] code);
      logic [7:0] pat;
      case (code)
         4'd0:       pat = 8'b11101011;
         4'd1:       pat = 8'b01100000;
         4'd2:       pat = 8'b11000111;
         4'd3:       pat = 8'b11100101;
         4'd4:       pat = 8'b01101100;
         4'd5:       pat = 8'b10101101;
         4'd6:       pat = 8'b10101111;
         4'd7:       pat = 8'b11100000;
         4'd8:       pat = 8'b11101111;
         4'd9:       pat = 8'b11101100;
         CODE_MINUS: pat = 8'b00000100;
         default:    pat = 8'b00000000;
      endcase
      return pat;
   endfunction

endpackage

### rtl/ssnf_front.sv
`timescale 1ns / 1ps
module ssnf_front import ssnf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_valid,
   output logic     csr_ready,
   input  logic     csr_data,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  logic     q_full,
   output push_type push
);

   logic        enabled_ff;
   logic        enabled_in;
   logic        neg;
   logic [31:0] mag;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   always_comb begin
      enabled_in = enabled_ff;
      if (csr_valid) begin
         enabled_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else begin
         enabled_ff <= enabled_in;
      end
   end

   assign neg = req_data.value[31];
   assign mag = neg ? (32'd0 - req_data.value) : req_data.value;

   // drop the beat while enabled is low
   always_comb begin
      push.valid     = req_valid && !q_full && enabled_ff;
      push.cls.mag   = mag;
      push.cls.neg   = neg;
      push.cls.pos   = !neg && (req_data.value != 32'sd0);
      push.cls.mark  = mag >= 32'(MAG_MARK_MIN);
      push.cls.alert = req_data.alert_bit;
      push.cls.fpm   = req_data.fpm_bit;
      push.cls.ft    = req_data.ft_bit;
   end

endmodule

### rtl/ssnf_queue.sv
`timescale 1ns / 1ps
module ssnf_queue import ssnf_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     q_full,
   output logic     q_valid,
   output cls_type  q_data,
   input  logic     q_pop
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cls_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_pop;

   assign q_full  = count_ff == CW'(DEPTH);
   assign q_valid = count_ff != '0;
   assign q_data  = mem_ff[rd_ptr_ff];
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push.valid, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.cls;
      end
   end

endmodule

### rtl/ssnf_back.sv
`timescale 1ns / 1ps
module ssnf_back import ssnf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cls_type q_data,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int NST = 7;

   typedef struct packed {
      logic [31:0]      mag;
      logic [17:0]      qe;
      logic [17:0]      rem;
      logic [16:0]      num;
      logic [4:0][3:0]  dig;
      logic             neg;
      logic             pos;
      logic             mark;
      logic             alert;
      logic             fpm;
      logic             ft;
   } pipe_type;

   pipe_type        st_ff [NST];
   pipe_type        st_in [NST];
   logic [NST-1:0]  vl_ff, vl_in;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_data_ff, out_data_in;
   logic            adv;

   logic [50:0]     prod0;
   logic [34:0]     prod1;
   logic [31:0]     diff1;
   logic [16:0]     mod1;
   logic [16:0]     mod2;
   logic [18:0]     recip0;
   logic [36:0]     prod_d [4];
   logic [16:0]     quo_d  [4];
   logic [16:0]     sub_d  [4];

   logic [4:0][3:0] dg;
   logic [4:0][3:0] code;
   logic            lead;

   // the whole back pipeline moves when the output register can take a beat
   assign adv       = !out_valid_ff || !rsp_stall;
   assign q_pop     = adv;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      // estimate the quotient by the reduction modulus
      st_in[0]       = '0;
      st_in[0].mag   = q_data.mag;
      st_in[0].neg   = q_data.neg;
      st_in[0].pos   = q_data.pos;
      st_in[0].mark  = q_data.mark;
      st_in[0].alert = q_data.alert;
      st_in[0].fpm   = q_data.fpm;
      st_in[0].ft    = q_data.ft;
      recip0         = q_data.pos ? RECIP_BIG : RECIP_SMALL;
      prod0          = 51'(q_data.mag) * 51'(recip0);
      st_in[0].qe    = prod0[49:32];

      // remainder off by at most one modulus
      st_in[1]       = st_ff[0];
      mod1           = st_ff[0].pos ? MOD_BIG : MOD_SMALL;
      prod1          = 35'(st_ff[0].qe) * 35'(mod1);
      diff1          = st_ff[0].mag - prod1[31:0];
      st_in[1].rem   = diff1[17:0];

      st_in[2]       = st_ff[1];
      mod2           = st_ff[1].pos ? MOD_BIG : MOD_SMALL;
      st_in[2].num   = (st_ff[1].rem >= 18'(mod2)) ?
                       17'(st_ff[1].rem - 18'(mod2)) : st_ff[1].rem[16:0];

      // peel one decimal digit per stage, units first
      for (int k = 0; k < 4; k++) begin
         st_in[3+k]          = st_ff[2+k];
         prod_d[k]           = 37'(st_ff[2+k].num) * 37'(DIV10_MUL);
         quo_d[k]            = 17'(prod_d[k] >> DIV10_SHIFT);
         sub_d[k]            = st_ff[2+k].num - ((quo_d[k] << 3) + (quo_d[k] << 1));
         st_in[3+k].num      = quo_d[k];
         st_in[3+k].dig[4-k] = sub_d[k][3:0];
      end
   end

   always_comb begin
      vl_in = vl_ff;
      if (adv) begin
         vl_in = {vl_ff[NST-2:0], q_valid};
      end
   end

   // blank leading zeros; the one just before the first nonzero digit turns into minus for a negative value
   always_comb begin
      dg      = st_ff[NST-1].dig;
      dg[0]   = st_ff[NST-1].num[3:0];
      code    = dg;
      lead    = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (lead && dg[i] == 4'd0) begin
            code[i] = (st_ff[NST-1].neg && dg[i+1] != 4'd0) ? CODE_MINUS : CODE_BLANK;
         end else begin
            lead = 1'b0;
         end
      end
      out_data_in.seg_byte0 = seg_pattern(code[0]) | (st_ff[NST-1].alert ? MARK_BIT : 8'h00);
      out_data_in.seg_byte1 = seg_pattern(code[1]) | (st_ff[NST-1].mark ? MARK_BIT : 8'h00);
      out_data_in.seg_byte2 = seg_pattern(code[2]) | (st_ff[NST-1].fpm ? MARK_BIT : 8'h00);
      out_data_in.seg_byte3 = seg_pattern(code[3]);
      out_data_in.seg_byte4 = seg_pattern(code[4]) | (st_ff[NST-1].ft ? MARK_BIT : 8'h00);
      out_valid_in = adv ? vl_ff[NST-1] : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         vl_ff        <= vl_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < NST; s++) begin
            st_ff[s] <= st_in[s];
         end
         out_data_ff <= out_data_in;
      end
   end

endmodule

### rtl/seven_segment_number_formatter.sv
`timescale 1ns / 1ps
// channel  dir  handshake              payload
// req      in   req_valid / req_stall  req_data (req_type)
// rsp      out  rsp_valid / rsp_stall  rsp_data (rsp_type)
// csr      in   csr_valid / csr_ready  csr_data (enabled)
//
// One value per cycle sustained while no rsp stall holds the back pipeline; a
// request beat is classified and queued by the front in its accept cycle, and
// the back runs two multiply stages, one correction stage, four digit stages
// and the output register. Reset is synchronous and clears enabled, the queue
// and all valid bits. A rsp stall on a held result freezes the back pipeline;
// the queue keeps taking request beats until it holds QUEUE_DEPTH items, then
// req_stall rises. Request beats taken while enabled is low are dropped.
module seven_segment_number_formatter import ssnf_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   push_type push;
   logic     q_full;
   logic     q_valid;
   cls_type  q_data;
   logic     q_pop;

   ssnf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push)
   );

   ssnf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .q_full  (q_full),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_pop   (q_pop)
   );

   ssnf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (req_valid && !req_stall))
      else $error("queue push without an accepted request beat");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push.valid)
      else $error("queue push while full");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

### verif/seven_segment_number_formatter_tb.sv
`timescale 1ns / 1ps
module seven_segment_number_formatter_tb;
   import ssnf_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 90;

   // segment patterns by digit code, code 0 in the low byte
   localparam logic [11:0][7:0] SEGMENT_ROM = {
      8'h04, 8'h00, 8'hEC, 8'hEF, 8'hE0, 8'hAF,
      8'hAD, 8'h6C, 8'hE5, 8'hC7, 8'h60, 8'hEB
   };

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_kind_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_values[$];
   rsp_type expected_displays[$];
   logic    display_enabled = 1'b0;
   int      mismatches = 0;
   int      displays_checked = 0;
   int      cycle_count = 0;

   int             gap_left = 0;
   int             burst_left = 1;
   int             window_left = 0;
   int             hold_left = 0;
   logic           long_hold_done = 1'b0;
   stall_kind_type stall_kind = STALL_NONE;
   logic [1:0]     periodic_phase = '0;

   seven_segment_number_formatter dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type predict_display(req_type item);
      logic [31:0] raw;
      logic [31:0] mag;
      logic [31:0] reduced;
      logic        neg;
      logic        pos;
      logic [3:0]  digit [5];
      logic [7:0]  mark;
      int          k;
      rsp_type     disp;
      raw = item.value;
      neg = raw[31];
      pos = !neg && (raw != 32'd0);
      mag = neg ? (32'd0 - raw) : raw;
      reduced = pos ? (mag % 32'd100000) : (mag % 32'd10000);
      for (k = 4; k >= 0; k--) begin
         digit[k] = 4'(reduced % 32'd10);
         reduced = reduced / 32'd10;
      end
      // blank leading zeros; the one before the first nonzero digit carries the sign
      for (k = 0; k < 4 && digit[k] == 4'd0; k++) begin
         if (digit[k + 1] != 4'd0 && neg) begin
            digit[k] = CODE_MINUS;
         end else begin
            digit[k] = CODE_BLANK;
         end
      end
      mark = (mag >= 32'd1000) ? MARK_BIT : 8'h00;
      disp.seg_byte0 = SEGMENT_ROM[digit[0]] | (item.alert_bit ? MARK_BIT : 8'h00);
      disp.seg_byte1 = SEGMENT_ROM[digit[1]] | mark;
      disp.seg_byte2 = SEGMENT_ROM[digit[2]] | (item.fpm_bit ? MARK_BIT : 8'h00);
      disp.seg_byte3 = SEGMENT_ROM[digit[3]];
      disp.seg_byte4 = SEGMENT_ROM[digit[4]] | (item.ft_bit ? MARK_BIT : 8'h00);
      return disp;
   endfunction

   task automatic report_mismatch(input string text);
      $display("mismatch at cycle %0d: %s", cycle_count, text);
      mismatches++;
   endtask

   task automatic check_byte(input string field, input logic [7:0] got,
                             input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("display %0d %s got %02h want %02h",
                                   displays_checked, field, got, want));
      end
   endtask

   task automatic queue_value(input logic [31:0] v, input logic [2:0] flags);
      req_type item;
      item.value     = v;
      item.alert_bit = flags[2];
      item.fpm_bit   = flags[1];
      item.ft_bit    = flags[0];
      pending_values.push_back(item);
   endtask

   function automatic logic [31:0] random_value();
      logic [31:0] v;
      int          sgn;
      sgn = ($urandom_range(0, 1) == 0) ? 1 : -1;
      case ($urandom_range(0, 6))
         0, 1: v = $urandom;
         2: v = 32'(int'($urandom_range(0, 199998)) - 99999);
         // near a multiple of ten thousand or one hundred thousand
         3: v = 32'(sgn * int'($urandom_range(0, 40)) * 10000 + int'($urandom_range(0, 2)) - 1);
         4: v = 32'(int'($urandom_range(0, 2000)) - 1000);
         5: v = 32'(int'($urandom_range(0, 20)) - 10);
         default: begin
            case ($urandom_range(0, 3))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'h8000_0000 + $urandom_range(0, 15);
               default: v = 32'h7FFF_FFFF - $urandom_range(0, 15);
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic queue_random(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         queue_value(random_value(), 3'($urandom_range(0, 7)));
      end
   endtask

   task automatic write_enabled(input logic v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      display_enabled = v;
   endtask

   // wait until every item is accepted and every display is checked, then let
   // the pipeline drain so that any display it still holds is seen by the monitor
   task automatic settle_block();
      do @(negedge clock);
      while (pending_values.size() != 0 || req_valid || expected_displays.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // request driver: bursts of beats with random gaps, hold while stalled
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall && display_enabled) begin
            expected_displays.push_back(predict_display(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || pending_values.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0) begin
                  gap_left <= gap_left - 1;
               end
            end else begin
               req_data  <= pending_values.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // response stall: windows of differing patterns, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!long_hold_done && displays_checked >= 200) begin
         rsp_stall      <= 1'b1;
         hold_left      <= HOLD_CYCLES;
         long_hold_done <= 1'b1;
      end else begin
         periodic_phase <= periodic_phase + 2'd1;
         if (window_left == 0) begin
            stall_kind  <= stall_kind_type'($urandom_range(0, 3));
            window_left <= $urandom_range(16, 80);
         end else begin
            window_left <= window_left - 1;
         end
         case (stall_kind)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 9) < 3);
            STALL_PERIODIC: rsp_stall <= periodic_phase[1];
            default:        rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_displays.size() == 0) begin
            report_mismatch($sformatf("unexpected display %h", rsp_data));
         end else begin
            want = expected_displays.pop_front();
            check_byte("seg_byte0", rsp_data.seg_byte0, want.seg_byte0);
            check_byte("seg_byte1", rsp_data.seg_byte1, want.seg_byte1);
            check_byte("seg_byte2", rsp_data.seg_byte2, want.seg_byte2);
            check_byte("seg_byte3", rsp_data.seg_byte3, want.seg_byte3);
            check_byte("seg_byte4", rsp_data.seg_byte4, want.seg_byte4);
         end
         displays_checked <= displays_checked + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // still disabled from reset: every beat is dropped
      @(negedge clock);
      queue_random(8);
      settle_block();

      write_enabled(1'b1);
      @(negedge clock);
      queue_value(32'd0, 3'b000);
      queue_value(32'd1, 3'b111);
      queue_value(32'hFFFF_FFFF, 3'b100);
      queue_value(32'd9, 3'b010);
      queue_value(32'd10, 3'b001);
      queue_value(32'd999, 3'b000);
      queue_value(32'd1000, 3'b111);
      queue_value(32'(-999), 3'b101);
      queue_value(32'(-1000), 3'b010);
      queue_value(32'(-9999), 3'b000);
      queue_value(32'(-10000), 3'b111);
      queue_value(32'(-20000), 3'b011);
      queue_value(32'(-12345), 3'b110);
      queue_value(32'(-100), 3'b000);
      queue_value(32'(-5), 3'b001);
      queue_value(32'd99999, 3'b111);
      queue_value(32'd100000, 3'b000);
      queue_value(32'd100001, 3'b100);
      queue_value(32'd123456, 3'b010);
      queue_value(32'd50000, 3'b001);
      queue_value(32'h7FFF_FFFF, 3'b111);
      queue_value(32'h8000_0000, 3'b000);
      queue_value(32'h8000_0001, 3'b101);
      queue_value(32'hAAAA_AAAA, 3'b010);
      queue_value(32'h5555_5555, 3'b111);
      settle_block();

      write_enabled(1'b0);
      @(negedge clock);
      queue_random(20);
      settle_block();

      write_enabled(1'b1);
      @(negedge clock);
      queue_random(320);
      settle_block();

      write_enabled(1'b0);
      @(negedge clock);
      queue_random(12);
      settle_block();

      write_enabled(1'b1);
      write_enabled(1'b1);
      @(negedge clock);
      queue_random(310);
      settle_block();

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
